/* rtl/core/bccc_pkg.sv */
// Shared types, constants and helpers for the buck constant-current controller.
`default_nettype none
package bccc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ACC_W         = 72;
  localparam int OPD_W         = 34;
  localparam int PROD_W        = 2 * OPD_W;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OV_LIMIT = 4'd0,
    REG_CUR_REF  = 4'd1,
    REG_FILT_B0  = 4'd2,
    REG_PI_NOW   = 4'd3,
    REG_PI_PAST  = 4'd4,
    REG_LAG_NOW  = 4'd5,
    REG_LAG_PAST = 4'd6,
    REG_FF_GAIN  = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic        [14:0] ov_limit;
    logic        [14:0] cur_ref;
    logic        [16:0] filt_b0;
    logic signed [31:0] pi_now;
    logic signed [31:0] pi_past;
    logic signed [31:0] lag_now;
    logic signed [31:0] lag_past;
    logic        [30:0] ff_gain;
  } cfg_t;

  // product selects, in issue order
  typedef enum logic [3:0] {
    M_B0_IL   = 4'd0,
    M_B0_FIP  = 4'd1,
    M_A1_FOP  = 4'd2,
    M_PGN_E   = 4'd3,
    M_PGP_EP  = 4'd4,
    M_LB0_U   = 4'd5,
    M_LB1_LIP = 4'd6,
    M_LA1_LOP = 4'd7,
    M_FF      = 4'd8
  } msel_t;

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_ADD  = 2'd1,
    ACC_SUB  = 2'd2
  } acc_op_t;

  typedef enum logic [2:0] {
    FIN_NONE = 3'd0,
    FIN_FILT = 3'd1,
    FIN_PI   = 3'd2,
    FIN_LAG  = 3'd3,
    FIN_FF   = 3'd4,
    FIN_OV   = 3'd5
  } fin_t;

  typedef struct packed {
    logic    load;
    logic    mul_en;
    msel_t   sel;
    acc_op_t acc;
    fin_t    fin;
  } cmd_t;

  typedef struct packed {
    logic ov;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sh7FFF_FFFF);
    lo = -ACC_W'(64'sh8000_0000);
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] clampw(input logic signed [ACC_W-1:0] v,
                                                     input logic signed [ACC_W-1:0] lo,
                                                     input logic signed [ACC_W-1:0] hi);
    if (v > hi) begin
      clampw = hi;
    end else if (v < lo) begin
      clampw = lo;
    end else begin
      clampw = v;
    end
  endfunction

endpackage
`default_nettype wire

/* rtl/core/buck_constant_current_controller_unit.sv */
// Top level of the buck constant-current controller.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+-----------------------------------------
//   in       | in_valid / in_ready            | in_voltage_sample, in_inductor_current,
//            |                                | in_load_current
//   out      | out_valid / out_ready          | out_duty_cycle, out_protection_active
//   cfg      | cfg_we (no wait)               | cfg_index, cfg_data
//
// out_valid rises when the work ends: a check state (which goes straight
// to the result under overvoltage), then nine products issued in turn
// through one shared 34x34 multiplier, each followed by an accumulate
// state, plus a finish state per loop stage. in_ready is high only while
// no sample is in work and returns the cycle after the result transfer;
// the result register holds until out_ready. Reset is synchronous, active
// low; it restores register defaults and clears all loop history.
`default_nettype none
module buck_constant_current_controller_unit
  import bccc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic signed [15:0]    in_voltage_sample,
  input  wire logic signed [15:0]    in_inductor_current,
  input  wire logic signed [15:0]    in_load_current,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic             [16:0]    out_duty_cycle,
  output logic                       out_protection_active,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  bccc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bccc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bccc_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_voltage_sample     (in_voltage_sample),
    .in_inductor_current   (in_inductor_current),
    .in_load_current       (in_load_current),
    .out_duty_cycle        (out_duty_cycle),
    .out_protection_active (out_protection_active)
  );

endmodule
`default_nettype wire

/* rtl/core/bccc_cfg.sv */
// Configuration register file with index decode.
`default_nettype none
module bccc_cfg
  import bccc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_OV_LIMIT: cfg_nxt.ov_limit = cfg_data[14:0];
        REG_CUR_REF:  cfg_nxt.cur_ref  = cfg_data[14:0];
        REG_FILT_B0:  cfg_nxt.filt_b0  = cfg_data[16:0];
        REG_PI_NOW:   cfg_nxt.pi_now   = cfg_data;
        REG_PI_PAST:  cfg_nxt.pi_past  = cfg_data;
        REG_LAG_NOW:  cfg_nxt.lag_now  = cfg_data;
        REG_LAG_PAST: cfg_nxt.lag_past = cfg_data;
        REG_FF_GAIN:  cfg_nxt.ff_gain  = cfg_data[30:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ov_limit <= 15'd18944;
      cfg_r.cur_ref  <= 15'd1024;
      cfg_r.filt_b0  <= '0;
      cfg_r.pi_now   <= '0;
      cfg_r.pi_past  <= '0;
      cfg_r.lag_now  <= 32'sd65536;
      cfg_r.lag_past <= '0;
      cfg_r.ff_gain  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

/* rtl/core/bccc_ctrl.sv */
// Sequencer: issues multiply, accumulate and finish commands for one sample.
`default_nettype none
module bccc_ctrl
  import bccc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  sts_t      sts,
  output cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_MUL   = 6'b000100,
    S_ACC   = 6'b001000,
    S_FIN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  msel_t      sel;
  fin_t       grp_fin;
  logic       grp_end;

  assign sel = msel_t'(step_r);

  always_comb begin
    grp_end = 1'b1;
    grp_fin = FIN_NONE;
    unique case (sel)
      M_A1_FOP:  grp_fin = FIN_FILT;
      M_PGP_EP:  grp_fin = FIN_PI;
      M_LA1_LOP: grp_fin = FIN_LAG;
      M_FF:      grp_fin = FIN_FF;
      default:   grp_end = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cmd        = '{load: 1'b0, mul_en: 1'b0, sel: sel, acc: ACC_NONE, fin: FIN_NONE};
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.ov) begin
          cmd.fin   = FIN_OV;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_ACC;
      end
      S_ACC: begin
        case (sel) inside
          M_A1_FOP, M_LA1_LOP, M_FF: cmd.acc = ACC_SUB;
          default:                   cmd.acc = ACC_ADD;
        endcase
        if (grp_end) begin
          state_nxt = S_FIN;
        end else begin
          step_nxt  = step_r + 4'd1;
          state_nxt = S_MUL;
        end
      end
      S_FIN: begin
        cmd.fin = grp_fin;
        if (sel == M_FF) begin
          state_nxt = S_OUT;
        end else begin
          step_nxt  = step_r + 4'd1;
          state_nxt = S_MUL;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bccc_dp.sv */
// Datapath: shared multiplier, accumulator, loop state and result register.
`default_nettype none
module bccc_dp
  import bccc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  cfg_t                    cfg,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  wire logic signed [15:0] in_voltage_sample,
  input  wire logic signed [15:0] in_inductor_current,
  input  wire logic signed [15:0] in_load_current,
  output logic             [16:0] out_duty_cycle,
  output logic                    out_protection_active
);

  localparam int    SHL   = (FRAC_BITS >= 10) ? FRAC_BITS - 10 : 0;
  localparam int    SHR   = (FRAC_BITS >= 10) ? 0 : 10 - FRAC_BITS;
  localparam longint QONE = 64'sd1 <<< FRAC_BITS;
  localparam longint QP9  = (9 * QONE + 5) / 10;
  localparam longint QP1  = (QONE + 5) / 10;
  localparam longint QP3  = (3 * QONE + 5) / 10;

  localparam logic signed [ACC_W-1:0] A_ONE  = ACC_W'(QONE);
  localparam logic signed [ACC_W-1:0] A_P9   = ACC_W'(QP9);
  localparam logic signed [ACC_W-1:0] A_P1   = ACC_W'(QP1);
  localparam logic signed [ACC_W-1:0] A_P3   = ACC_W'(QP3);
  localparam logic signed [ACC_W-1:0] A_ZERO = '0;

  // sample registers
  logic signed [15:0]       v_r;
  logic signed [OPD_W-1:0]  il_r, io_r;
  // loop state
  logic signed [31:0] fip_r, fop_r, ep_r, pop_r, lip_r, lop_r, ffp_r, lcp_r;
  // intermediates
  logic signed [31:0]       e_r, uc_r, ly_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic            [16:0]   duty_r;
  logic                     prot_r;

  logic signed [OPD_W-1:0] ref_q, il_q, io_q, opa, opb, ff_sum;
  logic signed [ACC_W-1:0] a1_w, la1_w, prod_sh, y_w, e_w, u_w, uc_w, ly_w, ff_w, d_w;
  logic signed [31:0]      a1_s, la1_s;
  logic            [47:0]  duty_w;

  function automatic logic signed [OPD_W-1:0] from_q10(input logic signed [OPD_W-1:0] x);
    from_q10 = (x <<< SHL) >>> SHR;
  endfunction

  function automatic logic signed [ACC_W-1:0] ext32(input logic signed [31:0] x);
    ext32 = ACC_W'(x);
  endfunction

  assign ref_q = from_q10(OPD_W'($signed({1'b0, cfg.cur_ref})));
  assign il_q  = from_q10(OPD_W'(in_inductor_current));
  assign io_q  = from_q10(OPD_W'(in_load_current));

  assign a1_w  = (ACC_W'($signed({1'b0, cfg.filt_b0})) <<< 1) - A_ONE;
  assign a1_s  = sat32(a1_w);
  assign la1_w = ext32(cfg.lag_now) + ext32(cfg.lag_past) - A_ONE;
  assign la1_s = sat32(la1_w);

  assign ff_sum = (ref_q - io_r) + (ref_q - OPD_W'(lcp_r));

  assign sts.ov = (v_r >= $signed({1'b0, cfg.ov_limit}));

  always_comb begin
    unique case (cmd.sel)
      M_B0_IL:   begin opa = OPD_W'($signed({1'b0, cfg.filt_b0})); opb = il_r; end
      M_B0_FIP:  begin opa = OPD_W'($signed({1'b0, cfg.filt_b0})); opb = OPD_W'(fip_r); end
      M_A1_FOP:  begin opa = OPD_W'(a1_s);          opb = OPD_W'(fop_r); end
      M_PGN_E:   begin opa = OPD_W'(cfg.pi_now);    opb = OPD_W'(e_r); end
      M_PGP_EP:  begin opa = OPD_W'(cfg.pi_past);   opb = OPD_W'(ep_r); end
      M_LB0_U:   begin opa = OPD_W'(cfg.lag_now);   opb = OPD_W'(uc_r); end
      M_LB1_LIP: begin opa = OPD_W'(cfg.lag_past);  opb = OPD_W'(lip_r); end
      M_LA1_LOP: begin opa = OPD_W'(la1_s);         opb = OPD_W'(lop_r); end
      M_FF:      begin opa = OPD_W'($signed({1'b0, cfg.ff_gain})); opb = ff_sum; end
      default:   begin opa = '0; opb = '0; end
    endcase
  end

  // floor rounding of the product
  assign prod_sh = ACC_W'(prod_r >>> FRAC_BITS);

  assign y_w    = ext32(sat32(acc_r));
  assign e_w    = ext32(sat32(ACC_W'(ref_q) - y_w));
  assign u_w    = clampw(acc_r, A_ZERO, A_ONE);
  assign uc_w   = clampw(u_w, A_P1, A_P9);
  assign ly_w   = ext32(sat32(acc_r));
  assign ff_w   = clampw(acc_r, A_ZERO, A_P3);
  assign d_w    = clampw(ext32(ly_r) + ff_w, A_P1, A_P9);
  assign duty_w = {d_w[31:0], 16'd0} >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r  <= in_voltage_sample;
      il_r <= il_q;
      io_r <= io_q;
    end
    if (cmd.mul_en) begin
      prod_r <= opa * opb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fip_r  <= '0;
      fop_r  <= '0;
      ep_r   <= '0;
      pop_r  <= '0;
      lip_r  <= '0;
      lop_r  <= '0;
      ffp_r  <= '0;
      lcp_r  <= '0;
      acc_r  <= '0;
      e_r    <= '0;
      uc_r   <= '0;
      ly_r   <= '0;
      duty_r <= '0;
      prot_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        acc_r <= '0;
      end
      case (cmd.acc)
        ACC_ADD: acc_r <= acc_r + prod_sh;
        ACC_SUB: acc_r <= acc_r - prod_sh;
        default: ;
      endcase
      unique case (cmd.fin)
        FIN_FILT: begin
          fop_r <= y_w[31:0];
          fip_r <= sat32(ACC_W'(il_r));
          e_r   <= e_w[31:0];
          acc_r <= ext32(pop_r);
        end
        FIN_PI: begin
          pop_r <= u_w[31:0];
          ep_r  <= e_r;
          uc_r  <= uc_w[31:0];
          acc_r <= '0;
        end
        FIN_LAG: begin
          lop_r <= ly_w[31:0];
          lip_r <= uc_r;
          ly_r  <= ly_w[31:0];
          acc_r <= ext32(ffp_r);
        end
        FIN_FF: begin
          ffp_r  <= ff_w[31:0];
          lcp_r  <= sat32(ACC_W'(io_r));
          duty_r <= duty_w[16:0];
          prot_r <= 1'b0;
        end
        FIN_OV: begin
          ffp_r  <= '0;
          lcp_r  <= '0;
          duty_r <= '0;
          prot_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_duty_cycle        = duty_r;
  assign out_protection_active = prot_r;

endmodule
`default_nettype wire
